>>> src/cqt_pkg.sv
package cqt_pkg;

  // default size limits
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  // pipeline depths
  localparam int DIV_STEPS    = 33;
  localparam int CORDIC_STEPS = 20;

  // inverse CORDIC gain, Q2.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // register indexes
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_RADIUS  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT  = 2'd3;

  // one corner to generate
  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic        last;
    logic        bad;
  } vtx_t;

  // one restoring divider: partial remainder, numerator bits shifting out,
  // quotient bits shifting in
  typedef struct packed {
    logic [10:0] rem;
    logic [32:0] nq;
  } dstep_t;

  typedef struct packed {
    dstep_t u;
    dstep_t v;
    dstep_t y;
    logic   last;
    logic   bad;
  } div_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        pos_y;
    logic               last;
    logic               bad;
  } rot_t;

  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        pos_y;
    logic               last;
    logic               bad;
  } nrm_t;

  // arctan of 2^-k in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input int k);
    logic [29:0] a;
    case (k)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // one restoring division step, remainder kept below the divisor
  function automatic dstep_t div_step(input dstep_t a, input logic [10:0] d);
    logic [11:0] r2;
    dstep_t      o;
    r2 = {a.rem, a.nq[32]};
    if (r2 >= {1'b0, d}) begin
      o.rem = 11'(r2 - {1'b0, d});
      o.nq  = {a.nq[31:0], 1'b1};
    end else begin
      o.rem = r2[10:0];
      o.nq  = {a.nq[31:0], 1'b0};
    end
    return o;
  endfunction

  // Q2.30 to Q1.15, round half up, clamp to symmetric range
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [15:0] o;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      o = 16'sd32767;
    end else if (t < -34'sd32767) begin
      o = -16'sd32767;
    end else begin
      o = t[15:0];
    end
    return o;
  endfunction

endpackage

>>> src/cqt_issue.sv
module cqt_issue (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [9:0]    column_index,
  input  logic [9:0]    row_index,
  input  logic [10:0]   ncols,
  input  logic [10:0]   nrows,
  output cqt_pkg::vtx_t vtx,
  output logic          vtx_valid
);
  import cqt_pkg::*;

  logic        busy;
  logic [2:0]  corner;
  logic [10:0] ci;
  logic [10:0] cn;
  logic [10:0] rj;
  logic        bad;
  logic        last_now;
  logic        accept;
  logic        use_next_col;
  logic        use_next_row;
  logic [10:0] ci_inc;

  assign last_now = bad || (corner == 3'd5);
  assign in_stall = busy && !(adv && last_now);
  assign accept   = in_valid && !in_stall;
  assign ci_inc   = {1'b0, column_index} + 11'd1;

  // corner order (i,j) (i+1,j) (i+1,j+1) (i,j) (i+1,j+1) (i,j+1)
  assign use_next_col = (corner == 3'd1) || (corner == 3'd2) || (corner == 3'd4);
  assign use_next_row = (corner == 3'd2) || (corner == 3'd4) || (corner == 3'd5);

  // quad sequencer; a transfer while busy only happens on the last corner
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      corner    <= 3'd0;
      vtx_valid <= 1'b0;
    end else begin
      if (adv) begin
        vtx_valid <= busy;
      end
      if (accept) begin
        busy   <= 1'b1;
        corner <= 3'd0;
      end else if (busy && adv) begin
        corner <= corner + 3'd1;
        if (last_now) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // quad fields, latched on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      ci  <= {1'b0, column_index};
      rj  <= {1'b0, row_index};
      cn  <= (ci_inc == ncols) ? 11'd0 : ci_inc;
      bad <= ({1'b0, column_index} >= ncols) || ({1'b0, row_index} >= nrows);
    end
  end

  // corner register
  always_ff @(posedge clk) begin
    if (busy && adv) begin
      vtx.col  <= use_next_col ? cn : ci;
      vtx.row  <= use_next_row ? rj + 11'd1 : rj;
      vtx.last <= last_now;
      vtx.bad  <= bad;
    end
  end

endmodule

>>> src/cqt_divide.sv
module cqt_divide (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  cqt_pkg::vtx_t vtx,
  input  logic          vtx_valid,
  input  logic [10:0]   ncols,
  input  logic [10:0]   nrows,
  input  logic [15:0]   height,
  output cqt_pkg::div_t quo,
  output logic          quo_valid
);
  import cqt_pkg::*;

  vtx_t        pre;
  logic [26:0] row_h;
  logic        pre_valid;
  div_t        init;
  div_t        st [DIV_STEPS];
  logic        vld [DIV_STEPS];

  // row times height
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (adv) begin
      pre_valid <= vtx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre   <= vtx;
      row_h <= 27'(vtx.row) * 27'(height);
    end
  end

  // divider start values
  always_comb begin
    init.u.rem = pre.col;
    init.u.nq  = '0;
    init.v.rem = '0;
    init.v.nq  = {5'd0, pre.row, 17'd0};
    init.y.rem = '0;
    init.y.nq  = {5'd0, row_h, 1'b0};
    init.last  = pre.last;
    init.bad   = pre.bad;
  end

  // one quotient bit per stage for each divider
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    div_t src;
    logic src_valid;
    if (k == 0) begin : g_first
      assign src       = init;
      assign src_valid = pre_valid;
    end else begin : g_rest
      assign src       = st[k-1];
      assign src_valid = vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k].u    <= div_step(src.u, ncols);
        st[k].v    <= div_step(src.v, nrows);
        st[k].y    <= div_step(src.y, nrows);
        st[k].last <= src.last;
        st[k].bad  <= src.bad;
      end
    end
  end

  assign quo       = st[DIV_STEPS-1];
  assign quo_valid = vld[DIV_STEPS-1];

endmodule

>>> src/cqt_cordic.sv
module cqt_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  cqt_pkg::div_t quo,
  input  logic          quo_valid,
  output cqt_pkg::nrm_t nrm,
  output logic          nrm_valid
);
  import cqt_pkg::*;

  logic [32:0] phase_r;
  rot_t        cst [CORDIC_STEPS+1];
  logic        cvld [CORDIC_STEPS+1];

  // rounding: round(x) = floor((floor(2x) + 1) / 2)
  assign phase_r = quo.u.nq + 33'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld[0] <= 1'b0;
    end else if (adv) begin
      cvld[0] <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cst[0].x     <= CORDIC_X0;
      cst[0].y     <= '0;
      cst[0].z     <= {4'd0, phase_r[30:1]};
      cst[0].quad  <= phase_r[32:31];
      cst[0].tex_u <= 17'((18'(quo.u.nq[32:16]) + 18'd1) >> 1);
      cst[0].tex_v <= 17'((quo.v.nq[17:0] + 18'd1) >> 1);
      cst[0].pos_y <= 16'((quo.y.nq[17:0] + 18'd1) >> 1);
      cst[0].last  <= quo.last;
      cst[0].bad   <= quo.bad;
    end
  end

  // rotation stages
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] zs;
    logic signed [33:0] at;
    rot_t               nx;

    always_comb begin
      xs = cst[k].x;
      ys = cst[k].y;
      zs = cst[k].z;
      at = $signed({4'd0, atan_turn(k)});
      nx = cst[k];
      if (zs >= 0) begin
        nx.x = xs - (ys >>> k);
        nx.y = ys + (xs >>> k);
        nx.z = zs - at;
      end else begin
        nx.x = xs + (ys >>> k);
        nx.y = ys - (xs >>> k);
        nx.z = zs + at;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[k+1] <= 1'b0;
      end else if (adv) begin
        cvld[k+1] <= cvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cst[k+1] <= nx;
      end
    end
  end

  // quadrant fold and Q1.15 rounding
  logic signed [33:0] fx;
  logic signed [33:0] fy;
  logic signed [33:0] sv;
  logic signed [33:0] cv;

  always_comb begin
    fx = cst[CORDIC_STEPS].x;
    fy = cst[CORDIC_STEPS].y;
    case (cst[CORDIC_STEPS].quad)
      2'd0: begin
        sv = fy;
        cv = fx;
      end
      2'd1: begin
        sv = fx;
        cv = -fy;
      end
      2'd2: begin
        sv = -fy;
        cv = -fx;
      end
      default: begin
        sv = -fx;
        cv = fy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_valid <= 1'b0;
    end else if (adv) begin
      nrm_valid <= cvld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm.sin_v <= to_q15(sv);
      nrm.cos_v <= to_q15(cv);
      nrm.tex_u <= cst[CORDIC_STEPS].tex_u;
      nrm.tex_v <= cst[CORDIC_STEPS].tex_v;
      nrm.pos_y <= cst[CORDIC_STEPS].pos_y;
      nrm.last  <= cst[CORDIC_STEPS].last;
      nrm.bad   <= cst[CORDIC_STEPS].bad;
    end
  end

endmodule

>>> src/cylinder_quad_tessellator.sv
// While the output is not stalled, one vertex per cycle, six vertices per
// quad; an index out of range gives a single flagged vertex and then frees
// the input. The rate is set by the one-vertex-per-cycle output and the
// quad sequencer.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: 32 columns, 16 rows, radius 1.0, height 1.0.
module cylinder_quad_tessellator #(
  parameter int MAX_COLUMNS = cqt_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = cqt_pkg::DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         column_index,
  input  logic [9:0]         row_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic signed [15:0] pos_x,
  output logic [15:0]        pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic               normal_y,
  output logic signed [15:0] normal_z,
  output logic               bad_index,
  output logic               last_vertex
);
  import cqt_pkg::*;

  logic [10:0] columns_in_use;
  logic [10:0] rows_in_use;
  logic [14:0] radius_value;
  logic [15:0] total_height;
  logic [10:0] ncols;
  logic [10:0] nrows;
  logic        adv;
  vtx_t        vtx;
  logic        vtx_valid;
  div_t        quo;
  logic        quo_valid;
  nrm_t        nrm;
  logic        nrm_valid;
  logic signed [31:0] mx;
  logic signed [31:0] mz;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= 11'd32;
      rows_in_use    <= 11'd16;
      radius_value   <= 15'd256;
      total_height   <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: columns_in_use <= cfg_data[10:0];
        CFG_ROWS:    rows_in_use    <= cfg_data[10:0];
        CFG_RADIUS:  radius_value   <= cfg_data[14:0];
        CFG_HEIGHT:  total_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts limited to the supported size
  assign ncols = (32'(columns_in_use) > 32'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS)
                                                          : columns_in_use;
  assign nrows = (32'(rows_in_use) > 32'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_in_use;

  // whole pipeline moves when the output register can take a vertex
  assign adv = !out_valid || !out_stall;

  cqt_issue u_issue (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .column_index (column_index),
    .row_index    (row_index),
    .ncols        (ncols),
    .nrows        (nrows),
    .vtx          (vtx),
    .vtx_valid    (vtx_valid)
  );

  cqt_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .vtx       (vtx),
    .vtx_valid (vtx_valid),
    .ncols     (ncols),
    .nrows     (nrows),
    .height    (total_height),
    .quo       (quo),
    .quo_valid (quo_valid)
  );

  cqt_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .quo       (quo),
    .quo_valid (quo_valid),
    .nrm       (nrm),
    .nrm_valid (nrm_valid)
  );

  // radius scaling
  assign mx = 32'($signed({1'b0, radius_value})) * 32'(nrm.sin_v);
  assign mz = 32'($signed({1'b0, radius_value})) * 32'(nrm.cos_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= nrm_valid;
    end
  end

  // output register, fields cleared for a bad index
  always_ff @(posedge clk) begin
    if (adv) begin
      bad_index   <= nrm.bad;
      last_vertex <= nrm.last;
      normal_y    <= 1'b0;
      if (nrm.bad) begin
        tex_u    <= '0;
        tex_v    <= '0;
        pos_x    <= '0;
        pos_y    <= '0;
        pos_z    <= '0;
        normal_x <= '0;
        normal_z <= '0;
      end else begin
        tex_u    <= nrm.tex_u;
        tex_v    <= nrm.tex_v;
        pos_x    <= 16'((mx + 32'sd16384) >>> 15);
        pos_y    <= nrm.pos_y;
        pos_z    <= 16'((mz + 32'sd16384) >>> 15);
        normal_x <= nrm.sin_v;
        normal_z <= nrm.cos_v;
      end
    end
  end

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_index |-> last_vertex)
    else $error("bad index vertex not marked last");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_index |-> (tex_u == 17'd0) && (pos_y == 16'd0) && (normal_x == 16'sd0))
    else $error("bad index vertex carries data");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_index |-> (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
    else $error("texture coordinate above one");

endmodule
